[sv/ground_to_image_remap_address_core_defines.svh]
// ----------------------------------------------------------------------------
// ground_to_image_remap_address_core_defines
// assertion macros shared by the remap address core
// ----------------------------------------------------------------------------
`ifndef GROUND_TO_IMAGE_REMAP_ADDRESS_CORE_DEFINES_SVH
`define GROUND_TO_IMAGE_REMAP_ADDRESS_CORE_DEFINES_SVH

// same-cycle implication on clk, off during reset
`define G2I_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication on clk, off during reset
`define G2I_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/g2i_pkg.sv]
// ----------------------------------------------------------------------------
// g2i_pkg
// widths, register codes and constant tables of the remap address core
// ----------------------------------------------------------------------------
package g2i_pkg;

	localparam int MAX_DIM_DEF       = 4096;
	localparam int CORDIC_STAGES_DEF = 18;

	localparam int COORD_W  = 32;  // q16.16 coordinates
	localparam int EW       = 33;  // coordinate difference
	localparam int XW       = 52;  // cordic x/y datapath
	localparam int ZW       = 35;  // q30 angle accumulator
	localparam int AW       = 21;  // q4.16 angle
	localparam int NUW      = 22;  // shifted angle
	localparam int PW       = 36;  // size times angle
	localparam int NW       = 36;  // rounded dividend
	localparam int DW       = 18;  // twice the half aperture
	localparam int SIZE_W   = 13;
	localparam int IDX_W    = 12;
	localparam int HEIGHT_W = 31;
	localparam int ANG_W    = 19;
	localparam int FOV_W    = 17;
	localparam int DZK_W    = 32;

	localparam logic signed [ZW-1:0] PI_Q30 = 35'sd3373259426;
	localparam logic [29:0] INV_GAIN_Q30  = 30'd652032874;
	localparam logic [29:0] INV_GAIN_HALF = 30'd326016437;

	typedef enum logic [2:0] {
		REG_CAM_OFFSET_X = 3'd0,
		REG_CAM_OFFSET_Y = 3'd1,
		REG_CAM_HEIGHT   = 3'd2,
		REG_YAW_ANGLE    = 3'd3,
		REG_PITCH_ANGLE  = 3'd4,
		REG_HALF_FOV     = 3'd5,
		REG_IMAGE_ROWS   = 3'd6,
		REG_IMAGE_COLS   = 3'd7
	} reg_index_t;

	typedef struct packed {
		logic valid;
		logic neg_r;
		logic neg_c;
		logic ovf_r;
		logic ovf_c;
	} div_flags_t;

	// atan(2^-i) in q30
	function automatic logic signed [ZW-1:0] atan_q30(input int idx);
		logic signed [ZW-1:0] v;
		case (idx)
			0:  v = 35'sh03243F6A8;
			1:  v = 35'sh01DAC6705;
			2:  v = 35'sh00FADBAFC;
			3:  v = 35'sh007F56EA6;
			4:  v = 35'sh003FEAB76;
			5:  v = 35'sh001FFD55B;
			6:  v = 35'sh000FFFAAA;
			7:  v = 35'sh0007FFF55;
			8:  v = 35'sh0003FFFEA;
			9:  v = 35'sh0001FFFFD;
			10: v = 35'sh0000FFFFF;
			11: v = 35'sh00007FFFF;
			12: v = 35'sh00003FFFF;
			13: v = 35'sh00001FFFF;
			14: v = 35'sh00000FFFF;
			15: v = 35'sh000007FFF;
			16: v = 35'sh000003FFF;
			17: v = 35'sh000001FFF;
			18: v = 35'sh000000FFF;
			19: v = 35'sh0000007FF;
			20: v = 35'sh0000003FF;
			21: v = 35'sh0000001FF;
			22: v = 35'sh0000000FF;
			23: v = 35'sh00000007F;
			default: v = '0;
		endcase
		return v;
	endfunction

	// q30 to q4.16, half away from zero
	function automatic logic signed [AW-1:0] round_q30(input logic signed [ZW-1:0] z);
		logic signed [ZW-1:0] t;
		t = z + (z[ZW-1] ? ZW'(8191) : ZW'(8192));
		return AW'(t >>> 14);
	endfunction

endpackage

[sv/g2i_cordic_cell.sv]
// ----------------------------------------------------------------------------
// g2i_cordic_cell
// one registered vectoring cordic iteration with a passed-along sideband
// ----------------------------------------------------------------------------
module g2i_cordic_cell #(
	parameter int STAGE = 0,
	parameter int SB_W  = 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            vi,
	input  logic signed [g2i_pkg::XW-1:0]   xi,
	input  logic signed [g2i_pkg::XW-1:0]   yi,
	input  logic signed [g2i_pkg::ZW-1:0]   zi,
	input  logic [SB_W-1:0]                 sbi,
	output logic                            vo,
	output logic signed [g2i_pkg::XW-1:0]   xo,
	output logic signed [g2i_pkg::XW-1:0]   yo,
	output logic signed [g2i_pkg::ZW-1:0]   zo,
	output logic [SB_W-1:0]                 sbo
);

	logic signed [g2i_pkg::XW-1:0] sx, sy, x_q, y_q;
	logic signed [g2i_pkg::ZW-1:0] at, z_q;
	logic [SB_W-1:0] sb_q;
	logic v_q;

	assign sx = yi >>> STAGE;
	assign sy = xi >>> STAGE;
	assign at = g2i_pkg::atan_q30(STAGE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= vi;
		end
	end

	// rotate toward the x axis
	always_ff @(posedge clk) begin
		if (en) begin
			sb_q <= sbi;
			if (!yi[g2i_pkg::XW-1]) begin
				x_q <= xi + sx;
				y_q <= yi - sy;
				z_q <= zi + at;
			end else begin
				x_q <= xi - sx;
				y_q <= yi + sy;
				z_q <= zi - at;
			end
		end
	end

	assign vo  = v_q;
	assign xo  = x_q;
	assign yo  = y_q;
	assign zo  = z_q;
	assign sbo = sb_q;

endmodule

[sv/g2i_div_cell.sv]
// ----------------------------------------------------------------------------
// g2i_div_cell
// one restoring quotient bit for the row and column divisions
// ----------------------------------------------------------------------------
module g2i_div_cell #(
	parameter int BIT = 0,
	parameter int QW  = 13,
	parameter int RW  = 31
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic [g2i_pkg::DW-1:0]      dvs,
	input  g2i_pkg::div_flags_t         fi,
	input  logic [RW-1:0]               rri,
	input  logic [RW-1:0]               rci,
	input  logic [QW-1:0]               qri,
	input  logic [QW-1:0]               qci,
	output g2i_pkg::div_flags_t         fo,
	output logic [RW-1:0]               rro,
	output logic [RW-1:0]               rco,
	output logic [QW-1:0]               qro,
	output logic [QW-1:0]               qco
);

	logic [RW-1:0] dsh, rr_q, rc_q;
	logic [QW-1:0] qr_q, qc_q, qbit;
	g2i_pkg::div_flags_t f_q;

	assign dsh  = RW'(dvs) << BIT;
	assign qbit = QW'(1) << BIT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_q <= '0;
		end else if (en) begin
			f_q <= fi;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (rri >= dsh) begin
				rr_q <= rri - dsh;
				qr_q <= qri | qbit;
			end else begin
				rr_q <= rri;
				qr_q <= qri;
			end
			if (rci >= dsh) begin
				rc_q <= rci - dsh;
				qc_q <= qci | qbit;
			end else begin
				rc_q <= rci;
				qc_q <= qci;
			end
		end
	end

	assign fo  = f_q;
	assign rro = rr_q;
	assign rco = rc_q;
	assign qro = qr_q;
	assign qco = qc_q;

endmodule

[sv/g2i_gain_div.sv]
// ----------------------------------------------------------------------------
// g2i_gain_div
// divides camera height by the inverse cordic gain with a reciprocal multiply
// ----------------------------------------------------------------------------
module g2i_gain_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [g2i_pkg::HEIGHT_W-1:0]      height,
	output logic                              busy,
	output logic [g2i_pkg::DZK_W-1:0]         dzk
);

	// floor(2^62 / gain constant), fits in 33 bits
	localparam logic [32:0] RECIP = 33'((64'd1 << 62) / 64'(g2i_pkg::INV_GAIN_Q30));

	logic [2:0] cnt_q;
	logic [46:0] plo_s1;
	logic [47:0] phi_s1;
	logic [31:0] qe_s2, qe_s3, rem_s3;
	logic [g2i_pkg::DZK_W-1:0] dzk_q;
	logic [63:0] psum;
	logic [60:0] num;
	logic [61:0] qg;

	// estimate is at most one below the rounded quotient
	assign psum = {phi_s1, 16'h0000} + 64'(plo_s1);
	// dividend is height * 2^30 plus half the divisor
	assign num  = {height, 30'd0} + 61'(g2i_pkg::INV_GAIN_HALF);
	assign qg   = 62'(qe_s2) * 62'(g2i_pkg::INV_GAIN_Q30);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 3'd3;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		plo_s1 <= 47'(height) * 47'(RECIP[15:0]);
		phi_s1 <= 48'(height) * 48'(RECIP[32:16]);
		qe_s2  <= psum[63:32];
		qe_s3  <= qe_s2;
		rem_s3 <= 32'(62'(num) - qg);
		dzk_q  <= (rem_s3 >= 32'(g2i_pkg::INV_GAIN_Q30)) ? qe_s3 + 32'd1 : qe_s3;
	end

	assign busy = cnt_q != '0;
	assign dzk  = dzk_q;

endmodule

[sv/ground_to_image_remap_address_core.sv]
// ----------------------------------------------------------------------------
// ground_to_image_remap_address_core
// ground point to camera pixel address for inverse perspective mapping
// ----------------------------------------------------------------------------
//  channel  dir  handshake              word
//  in       in   in_valid / in_stall    world_x, world_y
//  out      out  out_valid / out_stall  src_row, src_col, in_view
//  cfg      in   cfg_write              cfg_addr, cfg_data
//
//  one word per clock sustained while in_stall stays low; each word runs through the
//  two cordic cell rows and the quotient cell row on its way from input to output
//  after reset and after each cam_height write the gain scaling unit runs with
//  in_stall high
//  out_stall freezes the pipe only while a word waits behind the output register
// ----------------------------------------------------------------------------
`include "ground_to_image_remap_address_core_defines.svh"

module ground_to_image_remap_address_core #(
	parameter int MAX_DIM       = g2i_pkg::MAX_DIM_DEF,
	parameter int CORDIC_STAGES = g2i_pkg::CORDIC_STAGES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [g2i_pkg::COORD_W-1:0]   world_x,
	input  logic signed [g2i_pkg::COORD_W-1:0]   world_y,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [g2i_pkg::IDX_W-1:0]            src_row,
	output logic [g2i_pkg::IDX_W-1:0]            src_col,
	output logic                                 in_view,
	input  logic                                 cfg_write,
	input  logic [2:0]                           cfg_addr,
	input  logic [g2i_pkg::COORD_W-1:0]          cfg_data
);

	localparam int N    = CORDIC_STAGES;
	localparam int QW   = $clog2(MAX_DIM) + 1;
	localparam int RW   = g2i_pkg::DW + QW;
	localparam int CMPW = (g2i_pkg::NW > RW) ? g2i_pkg::NW : RW;
	localparam int QCW  = (QW > g2i_pkg::SIZE_W) ? QW : g2i_pkg::SIZE_W;
	localparam int XW   = g2i_pkg::XW;
	localparam int ZW   = g2i_pkg::ZW;
	localparam int AW   = g2i_pkg::AW;
	localparam int EW   = g2i_pkg::EW;
	localparam int SZW  = g2i_pkg::SIZE_W;

	// configuration registers
	logic signed [g2i_pkg::COORD_W-1:0] cam_offset_x_q, cam_offset_y_q;
	logic [g2i_pkg::HEIGHT_W-1:0]       cam_height_q;
	logic signed [g2i_pkg::ANG_W-1:0]   yaw_angle_q, pitch_angle_q;
	logic [g2i_pkg::FOV_W-1:0]          half_fov_q;
	logic [SZW-1:0]                     image_rows_q, image_cols_q;
	logic                               start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_offset_x_q <= 32'sd262144;
			cam_offset_y_q <= -32'sd655360;
			cam_height_q   <= 31'd327680;
			yaw_angle_q    <= 19'sd0;
			pitch_angle_q  <= 19'sd1638;
			half_fov_q     <= 17'd17150;
			image_rows_q   <= 13'd480;
			image_cols_q   <= 13'd640;
		end else if (cfg_write) begin
			unique case (g2i_pkg::reg_index_t'(cfg_addr))
				g2i_pkg::REG_CAM_OFFSET_X: cam_offset_x_q <= cfg_data;
				g2i_pkg::REG_CAM_OFFSET_Y: cam_offset_y_q <= cfg_data;
				g2i_pkg::REG_CAM_HEIGHT:   cam_height_q   <= cfg_data[g2i_pkg::HEIGHT_W-1:0];
				g2i_pkg::REG_YAW_ANGLE:    yaw_angle_q    <= cfg_data[g2i_pkg::ANG_W-1:0];
				g2i_pkg::REG_PITCH_ANGLE:  pitch_angle_q  <= cfg_data[g2i_pkg::ANG_W-1:0];
				g2i_pkg::REG_HALF_FOV:     half_fov_q     <= cfg_data[g2i_pkg::FOV_W-1:0];
				g2i_pkg::REG_IMAGE_ROWS:   image_rows_q   <= cfg_data[SZW-1:0];
				g2i_pkg::REG_IMAGE_COLS:   image_cols_q   <= cfg_data[SZW-1:0];
			endcase
		end
	end

	// recompute the gain-scaled height after reset and on each height write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b1;
		end else begin
			start_q <= cfg_write && (cfg_addr == g2i_pkg::REG_CAM_HEIGHT);
		end
	end

	logic                         gain_busy, busy;
	logic [g2i_pkg::DZK_W-1:0]    dzk;

	g2i_gain_div u_gain (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.height (cam_height_q),
		.busy   (gain_busy),
		.dzk    (dzk)
	);

	assign busy = start_q || gain_busy;

	// clamped image sizes and derived divisor; the user keeps them static while words are in flight, not enforced here
	logic [SZW-1:0]           rows_c, cols_c;
	logic signed [SZW:0]      rows_m1, cols_m1;
	logic [g2i_pkg::DW-1:0]   dvs;
	logic [RW-1:0]            dvs_top;

	assign rows_c  = (17'(image_rows_q) > 17'(MAX_DIM)) ? SZW'(MAX_DIM) : image_rows_q;
	assign cols_c  = (17'(image_cols_q) > 17'(MAX_DIM)) ? SZW'(MAX_DIM) : image_cols_q;
	assign rows_m1 = $signed({1'b0, rows_c}) - 14'sd1;
	assign cols_m1 = $signed({1'b0, cols_c}) - 14'sd1;
	assign dvs     = {half_fov_q, 1'b0};
	assign dvs_top = {dvs, {QW{1'b0}}};

	// global pipe advance: hold only when a word would run into a waiting result
	logic pipe_en;
	g2i_pkg::div_flags_t d_f [0:QW];
	logic out_valid_q;

	assign pipe_en  = !(out_valid_q && out_stall && d_f[QW].valid);
	assign in_stall = busy || !pipe_en;

	// stage 1: offsets from the camera foot
	logic v_s1;
	logic signed [EW-1:0] ex_s1, ey_s1;

	// stage 2: prescale and half-plane fold for the first cordic row
	logic v_s2;
	logic signed [XW-1:0] xe, ye, x_s2, y_s2;
	logic signed [ZW-1:0] z_s2;
	logic [1:0] sb_s2;
	logic fold;

	assign xe   = XW'(ey_s1) <<< 16;
	assign ye   = XW'(ex_s1) <<< 16;
	assign fold = xe[XW-1];

	// first cordic row: phi
	logic                  c1_v  [0:N];
	logic signed [XW-1:0]  c1_x  [0:N];
	logic signed [XW-1:0]  c1_y  [0:N];
	logic signed [ZW-1:0]  c1_z  [0:N];
	logic [1:0]            c1_sb [0:N];

	assign c1_v[0]  = v_s2;
	assign c1_x[0]  = x_s2;
	assign c1_y[0]  = y_s2;
	assign c1_z[0]  = z_s2;
	assign c1_sb[0] = sb_s2;

	for (genvar k = 0; k < N; k++) begin : g_phi
		g2i_cordic_cell #(.STAGE(k), .SB_W(2)) u_cell (
			.clk (clk), .arst_n (arst_n), .en (pipe_en),
			.vi (c1_v[k]), .xi (c1_x[k]), .yi (c1_y[k]), .zi (c1_z[k]), .sbi (c1_sb[k]),
			.vo (c1_v[k+1]), .xo (c1_x[k+1]), .yo (c1_y[k+1]), .zo (c1_z[k+1]),
			.sbo (c1_sb[k+1])
		);
	end

	// stage 3: round phi, start tilt from magnitude and scaled height
	logic signed [AW-1:0] phi16;
	logic v_s3;
	logic signed [XW-1:0] x_s3, y_s3;
	logic [AW:0] sb_s3;

	// sideband bit 1 marks the camera foot, bit 0 a nonzero x offset
	assign phi16 = c1_sb[N][1] ? '0 : g2i_pkg::round_q30(c1_z[N]);

	// second cordic row: tilt
	logic                  c2_v  [0:N];
	logic signed [XW-1:0]  c2_x  [0:N];
	logic signed [XW-1:0]  c2_y  [0:N];
	logic signed [ZW-1:0]  c2_z  [0:N];
	logic [AW:0]           c2_sb [0:N];

	assign c2_v[0]  = v_s3;
	assign c2_x[0]  = x_s3;
	assign c2_y[0]  = y_s3;
	assign c2_z[0]  = '0;
	assign c2_sb[0] = sb_s3;

	for (genvar k = 0; k < N; k++) begin : g_tilt
		g2i_cordic_cell #(.STAGE(k), .SB_W(AW + 1)) u_cell (
			.clk (clk), .arst_n (arst_n), .en (pipe_en),
			.vi (c2_v[k]), .xi (c2_x[k]), .yi (c2_y[k]), .zi (c2_z[k]), .sbi (c2_sb[k]),
			.vo (c2_v[k+1]), .xo (c2_x[k+1]), .yo (c2_y[k+1]), .zo (c2_z[k+1]),
			.sbo (c2_sb[k+1])
		);
	end

	// stages 4 to 8: angles to rounded dividends
	logic v_s4, v_s5, v_s6, v_s7;
	logic signed [AW-1:0] tilt_s4, phi_s4;
	logic signed [g2i_pkg::NUW-1:0] nu_s5, nv_s5;
	logic signed [g2i_pkg::PW-1:0] pr_s6, pc_s6;
	logic [g2i_pkg::NW-1:0] nr_s7, nc_s7;
	logic negr_s7, negc_s7;

	logic [g2i_pkg::NW-1:0] nr, nc;
	assign nr = pr_s6[g2i_pkg::PW-1] ? (g2i_pkg::NW'(half_fov_q) - g2i_pkg::NW'(pr_s6))
		: (g2i_pkg::NW'(pr_s6) + g2i_pkg::NW'(half_fov_q));
	assign nc = pc_s6[g2i_pkg::PW-1] ? (g2i_pkg::NW'(half_fov_q) - g2i_pkg::NW'(pc_s6))
		: (g2i_pkg::NW'(pc_s6) + g2i_pkg::NW'(half_fov_q));

	// quotient cell row
	logic [RW-1:0] d_rr [0:QW];
	logic [RW-1:0] d_rc [0:QW];
	logic [QW-1:0] d_qr [0:QW];
	logic [QW-1:0] d_qc [0:QW];
	g2i_pkg::div_flags_t f_s8;
	logic [RW-1:0] rr_s8, rc_s8;

	assign d_f[0]  = f_s8;
	assign d_rr[0] = rr_s8;
	assign d_rc[0] = rc_s8;
	assign d_qr[0] = '0;
	assign d_qc[0] = '0;

	for (genvar k = 0; k < QW; k++) begin : g_div
		g2i_div_cell #(.BIT(QW - 1 - k), .QW(QW), .RW(RW)) u_cell (
			.clk (clk), .arst_n (arst_n), .en (pipe_en), .dvs (dvs),
			.fi (d_f[k]), .rri (d_rr[k]), .rci (d_rc[k]), .qri (d_qr[k]), .qci (d_qc[k]),
			.fo (d_f[k+1]), .rro (d_rr[k+1]), .rco (d_rc[k+1]),
			.qro (d_qr[k+1]), .qco (d_qc[k+1])
		);
	end

	// valid bits of the plain stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			f_s8 <= '0;
		end else if (pipe_en) begin
			v_s1       <= in_valid && !busy;
			v_s2       <= v_s1;
			v_s3       <= c1_v[N];
			v_s4       <= c2_v[N];
			v_s5       <= v_s4;
			v_s6       <= v_s5;
			v_s7       <= v_s6;
			f_s8.valid <= v_s7;
			f_s8.neg_r <= negr_s7;
			f_s8.neg_c <= negc_s7;
			f_s8.ovf_r <= CMPW'(nr_s7) >= CMPW'(dvs_top);
			f_s8.ovf_c <= CMPW'(nc_s7) >= CMPW'(dvs_top);
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			ex_s1   <= EW'(world_x) - EW'(cam_offset_x_q);
			ey_s1   <= EW'(world_y) - EW'(cam_offset_y_q);
			// fold the left half-plane onto the right, base angle +-pi
			x_s2    <= fold ? -xe : xe;
			y_s2    <= fold ? -ye : ye;
			z_s2    <= fold ? (ex_s1[EW-1] ? -g2i_pkg::PI_Q30 : g2i_pkg::PI_Q30) : '0;
			sb_s2   <= {(ex_s1 == '0) && (ey_s1 == '0), ex_s1 != '0};
			x_s3    <= c1_x[N];
			y_s3    <= $signed(XW'({dzk, 16'h0000}));
			sb_s3   <= {c1_sb[N][0], phi16};
			// no x offset means no tilt
			tilt_s4 <= c2_sb[N][AW] ? g2i_pkg::round_q30(c2_z[N]) : '0;
			phi_s4  <= c2_sb[N][AW-1:0];
			nu_s5   <= g2i_pkg::NUW'(tilt_s4) - g2i_pkg::NUW'(pitch_angle_q)
				+ g2i_pkg::NUW'(half_fov_q);
			nv_s5   <= g2i_pkg::NUW'(phi_s4) - g2i_pkg::NUW'(yaw_angle_q)
				+ g2i_pkg::NUW'(half_fov_q);
			pr_s6   <= rows_m1 * nu_s5;
			pc_s6   <= cols_m1 * nv_s5;
			nr_s7   <= nr;
			nc_s7   <= nc;
			negr_s7 <= pr_s6[g2i_pkg::PW-1];
			negc_s7 <= pc_s6[g2i_pkg::PW-1];
			rr_s8   <= RW'(nr_s7);
			rc_s8   <= RW'(nc_s7);
		end
	end

	// bounds check on the quotients
	logic ok;
	assign ok = (half_fov_q != '0) && !d_f[QW].ovf_r && !d_f[QW].ovf_c
		&& (!d_f[QW].neg_r || (d_qr[QW] == '0)) && (!d_f[QW].neg_c || (d_qc[QW] == '0))
		&& (QCW'(d_qr[QW]) < QCW'(rows_c)) && (QCW'(d_qc[QW]) < QCW'(cols_c));

	// output register
	logic [g2i_pkg::IDX_W-1:0] src_row_q, src_col_q;
	logic in_view_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= d_f[QW].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || !out_stall) begin
			src_row_q <= ok ? g2i_pkg::IDX_W'(d_qr[QW]) : '0;
			src_col_q <= ok ? g2i_pkg::IDX_W'(d_qc[QW]) : '0;
			in_view_q <= ok;
		end
	end

	assign out_valid = out_valid_q;
	assign src_row   = src_row_q;
	assign src_col   = src_col_q;
	assign in_view   = in_view_q;

	// checks
	`G2I_ASSERT_NEXT(a_height_write_stalls, cfg_write && (cfg_addr == g2i_pkg::REG_CAM_HEIGHT), in_stall, "input taken while gain divider reloads")
	`G2I_ASSERT_SAME(a_zero_out_of_view, out_valid && !in_view, (src_row == '0) && (src_col == '0), "nonzero address on an out of view word")
	`G2I_ASSERT_SAME(a_in_bounds, out_valid && in_view, (13'(src_row) < image_rows_q) && (13'(src_col) < image_cols_q), "in view address outside the image")

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the ground to image remap address core: a local
// fixed point predictor computes row, column and in-view for each accepted
// word, and a checker compares every output word with the oldest prediction
// ----------------------------------------------------------------------------
module tb_top;

	localparam int LATENCY   = 2 * 18 + 12 + 10;
	localparam int WD_LIMIT  = 20000;
	localparam logic signed [63:0] PI_Q30_L = 64'sd3373259426;
	localparam logic [63:0] INV_GAIN_L = 64'd652032874;

	typedef struct packed {
		logic [11:0] row;
		logic [11:0] col;
		logic        vis;
	} pixel_addr_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] world_x = '0;
	logic signed [31:0] world_y = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [11:0] src_row;
	logic [11:0] src_col;
	logic in_view;
	logic cfg_write = 1'b0;
	logic [2:0] cfg_addr = '0;
	logic [31:0] cfg_data = '0;

	// predictor copy of the register file
	logic signed [31:0] m_off_x, m_off_y;
	logic [30:0] m_height;
	logic signed [18:0] m_yaw, m_pitch;
	logic [16:0] m_fov;
	logic [12:0] m_rows, m_cols;

	pixel_addr_t pending_addrs[$];
	int mismatches = 0;
	int words_sent = 0;
	int words_seen = 0;
	int in_views = 0;
	int idle_in_pct = 0;
	int idle_out_pct = 0;
	int quiet_cycles = 0;

	ground_to_image_remap_address_core dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// floor shift of a signed value
	function automatic logic signed [63:0] floor_shr(input logic signed [63:0] v, input int s);
		return v >>> s;
	endfunction

	// p / q rounded half away from zero, q positive
	function automatic logic signed [63:0] div_round(input logic signed [63:0] p,
			input logic signed [63:0] q);
		if (p >= 0)
			return (p + q / 2) / q;
		return -((-p + q / 2) / q);
	endfunction

	function automatic logic signed [63:0] atan_stage(input int i);
		logic signed [63:0] t[18];
		t = '{64'sh3243F6A8, 64'sh1DAC6705, 64'sh0FADBAFC, 64'sh07F56EA6,
			64'sh03FEAB76, 64'sh01FFD55B, 64'sh00FFFAAA, 64'sh007FFF55,
			64'sh003FFFEA, 64'sh001FFFFD, 64'sh000FFFFF, 64'sh0007FFFF,
			64'sh0003FFFF, 64'sh0001FFFF, 64'sh0000FFFF, 64'sh00007FFF,
			64'sh00003FFF, 64'sh00001FFF};
		return t[i];
	endfunction

	// vectoring rotation, x nonnegative; angle in q30, magnitude via mag
	function automatic logic signed [63:0] vector_angle(input logic signed [63:0] xi,
			input logic signed [63:0] yi, output logic signed [63:0] mag);
		logic signed [63:0] x, y, z, sx, sy;
		x = xi;
		y = yi;
		z = 0;
		for (int i = 0; i < 18; i++) begin
			sx = floor_shr(y, i);
			sy = floor_shr(x, i);
			if (y >= 0) begin
				x = x + sx; y = y - sy; z = z + atan_stage(i);
			end else begin
				x = x - sx; y = y + sy; z = z - atan_stage(i);
			end
		end
		mag = x;
		return z;
	endfunction

	function automatic pixel_addr_t predict_pixel(input logic signed [31:0] wx,
			input logic signed [31:0] wy);
		logic signed [63:0] ex, ey, phi30, tilt30, mag, dummy, x, y, base;
		logic signed [63:0] phi16, tilt16, alpha, rows, cols, nu, nv, ui, vi;
		logic [63:0] dzk;
		pixel_addr_t r;
		ex = 64'(wx) - 64'(m_off_x);
		ey = 64'(wy) - 64'(m_off_y);
		phi30 = 0;
		tilt30 = 0;
		mag = 0;
		if (ex != 0 || ey != 0) begin
			x = ey * 65536;
			y = ex * 65536;
			base = 0;
			if (x < 0) begin
				base = (y >= 0) ? PI_Q30_L : -PI_Q30_L;
				x = -x;
				y = -y;
			end
			phi30 = base + vector_angle(x, y, mag);
		end
		if (ex != 0) begin
			dzk = ((64'(m_height) << 30) + INV_GAIN_L / 2) / INV_GAIN_L;
			tilt30 = vector_angle(mag, $signed(dzk) * 65536, dummy);
		end
		phi16 = div_round(phi30, 16384);
		tilt16 = div_round(tilt30, 16384);
		alpha = 64'(m_fov);
		rows = (m_rows > 4096) ? 4096 : 64'(m_rows);
		cols = (m_cols > 4096) ? 4096 : 64'(m_cols);
		r = '0;
		if (alpha != 0) begin
			nu = tilt16 - 64'(m_pitch) + alpha;
			nv = phi16 - 64'(m_yaw) + alpha;
			ui = div_round((rows - 1) * nu, 2 * alpha);
			vi = div_round((cols - 1) * nv, 2 * alpha);
			if (ui >= 0 && ui < rows && vi >= 0 && vi < cols) begin
				r.row = ui[11:0];
				r.col = vi[11:0];
				r.vis = 1'b1;
			end
		end
		return r;
	endfunction

	// register write while the core is idle
	task automatic write_reg(input g2i_pkg::reg_index_t idx, input logic [31:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			g2i_pkg::REG_CAM_OFFSET_X: m_off_x = val;
			g2i_pkg::REG_CAM_OFFSET_Y: m_off_y = val;
			g2i_pkg::REG_CAM_HEIGHT:   m_height = val[30:0];
			g2i_pkg::REG_YAW_ANGLE:    m_yaw = val[18:0];
			g2i_pkg::REG_PITCH_ANGLE:  m_pitch = val[18:0];
			g2i_pkg::REG_HALF_FOV:     m_fov = val[16:0];
			g2i_pkg::REG_IMAGE_ROWS:   m_rows = val[12:0];
			default:                   m_cols = val[12:0];
		endcase
	endtask

	// send one word; valid held across back-to-back words
	task automatic send_word(input logic signed [31:0] wx, input logic signed [31:0] wy);
		while ($urandom_range(99) < idle_in_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		world_x <= wx;
		world_y <= wy;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_addrs.push_back(predict_pixel(wx, wy));
		words_sent++;
	endtask

	task automatic stop_sending();
		in_valid <= 1'b0;
	endtask

	// wait for all predictions to drain, then let the pipe settle
	task automatic drain();
		stop_sending();
		while (pending_addrs.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 40) @(posedge clk);
	endtask

	// receiver stall pattern
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < idle_out_pct);
	end

	// result checker
	always @(posedge clk) begin
		pixel_addr_t exp_addr;
		if (arst_n && out_valid && !out_stall) begin
			words_seen++;
			if (pending_addrs.size() == 0) begin
				$error("output word with no prediction waiting");
				mismatches++;
			end else begin
				exp_addr = pending_addrs.pop_front();
				if (in_view) in_views++;
				if (src_row !== exp_addr.row) begin
					$error("src_row expected %0d actual %0d", exp_addr.row, src_row);
					mismatches++;
				end
				if (src_col !== exp_addr.col) begin
					$error("src_col expected %0d actual %0d", exp_addr.col, src_col);
					mismatches++;
				end
				if (in_view !== exp_addr.vis) begin
					$error("in_view expected %0d actual %0d", exp_addr.vis, in_view);
					mismatches++;
				end
			end
		end
	end

	// watchdog on cycles without any accepted word
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WD_LIMIT) begin
			$display("watchdog expired");
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic logic signed [31:0] rand_near(input logic signed [31:0] c, input int span);
		return c + $signed($urandom_range(2 * span)) - span;
	endfunction

	// extremes of coordinates, the foot point, the zero x offset line
	task automatic test_directed();
		send_word(32'sh7FFFFFFF, 32'sh7FFFFFFF);
		send_word(32'sh80000000, 32'sh80000000);
		send_word(32'sh80000000, 32'sh7FFFFFFF);
		send_word(32'sh7FFFFFFF, 32'sh80000000);
		send_word(m_off_x, m_off_y);                 // point at camera foot
		send_word(m_off_x, m_off_y + 32'sd655360);   // zero x offset
		send_word(m_off_x, m_off_y - 32'sd655360);
		send_word(m_off_x + 1, m_off_y);
		send_word(m_off_x - 1, m_off_y);
		send_word(m_off_x + 32'sd65536, m_off_y + 32'sd1310720);
		send_word(m_off_x - 32'sd65536, m_off_y + 32'sd1310720);
		send_word(m_off_x + 32'sd32768, m_off_y + 32'sd6553600);
		send_word(32'sd0, 32'sd0);
		send_word(32'sh55555555, 32'shAAAAAAAA);
		send_word(32'shAAAAAAAA, 32'sh55555555);
		drain();
	endtask

	// mostly points around the camera that land inside the image
	task automatic test_random(input int n);
		logic signed [31:0] wx, wy;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0: begin
					wx = $urandom;
					wy = $urandom;
				end
				1: begin
					wx = m_off_x;
					wy = rand_near(m_off_y, 1 << 22);
				end
				default: begin
					wx = rand_near(m_off_x, 1 << $urandom_range(8, 20));
					wy = m_off_y + $signed($urandom_range(1 << 22));
				end
			endcase
			send_word(wx, wy);
		end
		drain();
	endtask

	// configuration sets including the register extremes
	task automatic test_configs();
		write_reg(g2i_pkg::REG_HALF_FOV, 32'd102943);
		write_reg(g2i_pkg::REG_IMAGE_ROWS, 32'd4096);
		write_reg(g2i_pkg::REG_IMAGE_COLS, 32'd2);
		write_reg(g2i_pkg::REG_YAW_ANGLE, 32'(-205887));
		write_reg(g2i_pkg::REG_PITCH_ANGLE, 32'd205887);
		write_reg(g2i_pkg::REG_CAM_HEIGHT, 32'h7FFFFFFF);
		test_random(100);
		write_reg(g2i_pkg::REG_CAM_OFFSET_X, 32'h80000000);
		write_reg(g2i_pkg::REG_CAM_OFFSET_Y, 32'h7FFFFFFF);
		write_reg(g2i_pkg::REG_CAM_HEIGHT, 32'd1);
		write_reg(g2i_pkg::REG_HALF_FOV, 32'd1);
		write_reg(g2i_pkg::REG_YAW_ANGLE, 32'd205887);
		write_reg(g2i_pkg::REG_PITCH_ANGLE, 32'(-205887));
		write_reg(g2i_pkg::REG_IMAGE_ROWS, 32'd2);
		write_reg(g2i_pkg::REG_IMAGE_COLS, 32'd4096);
		test_random(100);
		// large image size above the clamp, sizes zero and one
		write_reg(g2i_pkg::REG_IMAGE_ROWS, 32'h1FFF);
		write_reg(g2i_pkg::REG_IMAGE_COLS, 32'd1);
		write_reg(g2i_pkg::REG_HALF_FOV, 32'd60000);
		write_reg(g2i_pkg::REG_CAM_OFFSET_X, 32'd0);
		write_reg(g2i_pkg::REG_CAM_OFFSET_Y, 32'd0);
		write_reg(g2i_pkg::REG_YAW_ANGLE, 32'd0);
		write_reg(g2i_pkg::REG_PITCH_ANGLE, 32'd0);
		test_random(80);
		write_reg(g2i_pkg::REG_IMAGE_ROWS, 32'd0);
		write_reg(g2i_pkg::REG_IMAGE_COLS, 32'h1FFF);
		write_reg(g2i_pkg::REG_HALF_FOV, 32'h1FFFF);
		test_random(80);
		// a middle setting with many in-view pixels
		write_reg(g2i_pkg::REG_IMAGE_ROWS, 32'd480);
		write_reg(g2i_pkg::REG_IMAGE_COLS, 32'd640);
		write_reg(g2i_pkg::REG_HALF_FOV, 32'd40000);
		write_reg(g2i_pkg::REG_CAM_HEIGHT, 32'd327680);
		write_reg(g2i_pkg::REG_PITCH_ANGLE, 32'd30000);
		write_reg(g2i_pkg::REG_CAM_OFFSET_X, 32'd262144);
		write_reg(g2i_pkg::REG_CAM_OFFSET_Y, 32'(-655360));
		test_random(100);
	endtask

	initial begin
		m_off_x = 32'sd262144;
		m_off_y = -32'sd655360;
		m_height = 31'd327680;
		m_yaw = '0;
		m_pitch = 19'sd1638;
		m_fov = 17'd17150;
		m_rows = 13'd480;
		m_cols = 13'd640;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		idle_in_pct = 34; idle_out_pct = 63;
		test_random(400);
		idle_in_pct = 63; idle_out_pct = 34;
		test_random(400);
		idle_in_pct = 0; idle_out_pct = 0;
		test_directed();
		test_random(375);
		test_configs();
		$display("covered %0d words sent, %0d checked, %0d in view, default and extreme registers",
			words_sent, words_seen, in_views);
		$display("idle patterns: sender-heavy, receiver-heavy and full rate");
		if (mismatches == 0 && pending_addrs.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

[sim.f]
+incdir+sv
sv/g2i_pkg.sv
sv/g2i_cordic_cell.sv
sv/g2i_div_cell.sv
sv/g2i_gain_div.sv
sv/ground_to_image_remap_address_core.sv
test/tb_top.sv
